[hw/rtl/stbs_pkg.sv]
package stbs_pkg;

    // fixed field widths of the ports
    localparam int VAL_W   = 32;
    localparam int IDX_F_W = 10;
    localparam int CNT_W   = 11;
    localparam int LEN_W   = 11;

    // defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_DATA_WIDTH  = 32;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // search modes
    localparam logic [1:0] MODE_EXACT = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_LAST  = 2'd2;
    localparam logic [1:0] MODE_COUNT = 2'd3;

    // one search result
    typedef struct packed {
        logic               found;
        logic [IDX_F_W-1:0] match_index;
        logic [CNT_W-1:0]   match_count;
    } res_t;

endpackage

[hw/rtl/stbs_table.sv]
module stbs_table
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/stbs_ctrl.sv]
module stbs_ctrl
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int NMAX       = (TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047,
    localparam int PW         = $clog2(NMAX + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [LEN_W-1:0]      len,
    input  logic [VAL_W-1:0]      key,
    input  logic [1:0]            mode,
    output logic                  busy,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [DATA_WIDTH-1:0] rd_data,
    output logic                  res_valid,
    output res_t                  res,
    input  logic                  res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           low_reg, low_next;
    logic [PW-1:0]           hi1_reg, hi1_next;
    logic [PW-1:0]           mid_reg, mid_next;
    logic [PW-1:0]           hit_reg, hit_next;
    logic                    hit_valid_reg, hit_valid_next;
    logic [PW-1:0]           first_reg, first_next;
    logic [PW-1:0]           n_reg, n_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic [1:0]              mode_reg, mode_next;
    logic                    second_reg, second_next;
    res_t                    res_reg, res_next;

    logic [PW-1:0]           span;
    logic [PW-1:0]           mid;
    logic                    live;
    logic signed [DATA_WIDTH-1:0] entry;
    logic                    go_left;
    logic                    go_right;
    logic [PW-1:0]           n_start;

    // midpoint of the live window [low, hi1)
    assign span = hi1_reg - low_reg - PW'(1);
    assign mid  = low_reg + (span >> 1);
    assign live = low_reg < hi1_reg;

    assign entry = rd_data;

    // direction kept after a hit
    assign go_left  = (mode_reg == MODE_FIRST) || ((mode_reg == MODE_COUNT) && !second_reg);
    assign go_right = (mode_reg == MODE_LAST) || ((mode_reg == MODE_COUNT) && second_reg);

    // length saturated at the table depth, and at most 2047
    assign n_start = (32'(len) > 32'(NMAX)) ? PW'(NMAX) : PW'(len);

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        hi1_next       = hi1_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        hit_valid_next = hit_valid_reg;
        first_next     = first_reg;
        n_next         = n_reg;
        key_next       = key_reg;
        mode_next      = mode_reg;
        second_next    = second_reg;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next       = DATA_WIDTH'($signed(key));
                    mode_next      = mode;
                    n_next         = n_start;
                    low_next       = '0;
                    hi1_next       = n_start;
                    hit_valid_next = 1'b0;
                    second_next    = 1'b0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (live)
                begin
                    mid_next   = mid;
                    state_next = ST_CMP;
                end
                else if ((mode_reg == MODE_COUNT) && !second_reg && hit_valid_reg)
                begin
                    // leftmost found, now look for the rightmost
                    first_next     = hit_reg;
                    low_next       = '0;
                    hi1_next       = n_reg;
                    hit_valid_next = 1'b0;
                    second_next    = 1'b1;
                end
                else
                begin
                    res_next.found       = hit_valid_reg;
                    res_next.match_index = (hit_valid_reg && (mode_reg != MODE_COUNT))
                                         ? IDX_F_W'(hit_reg) : '0;
                    res_next.match_count = (hit_valid_reg && (mode_reg == MODE_COUNT))
                                         ? CNT_W'(hit_reg) - CNT_W'(first_reg) + CNT_W'(1)
                                         : '0;
                    state_next           = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (entry == key_reg)
                begin
                    hit_next       = mid_reg;
                    hit_valid_next = 1'b1;
                    if (go_left)
                    begin
                        hi1_next = mid_reg;
                    end
                    else if (go_right)
                    begin
                        low_next = mid_reg + PW'(1);
                    end
                    else
                    begin
                        // exact mode: close the window
                        low_next = hi1_reg;
                    end
                end
                else if (entry < key_reg)
                begin
                    low_next = mid_reg + PW'(1);
                end
                else
                begin
                    hi1_next = mid_reg;
                end
                state_next = ST_PROBE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            low_reg       <= '0;
            hi1_reg       <= '0;
            mid_reg       <= '0;
            hit_reg       <= '0;
            first_reg     <= '0;
            n_reg         <= '0;
            key_reg       <= '0;
            mode_reg      <= MODE_EXACT;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_valid_reg <= hit_valid_next;
            second_reg    <= second_next;
            low_reg       <= low_next;
            hi1_reg       <= hi1_next;
            mid_reg       <= mid_next;
            hit_reg       <= hit_next;
            first_reg     <= first_next;
            n_reg         <= n_next;
            key_reg       <= key_next;
            mode_reg      <= mode_next;
            res_reg       <= res_next;
        end
    end

    assign busy      = state_reg != ST_IDLE;
    assign rd_en     = (state_reg == ST_PROBE) && live;
    assign rd_addr   = IDX_W'(mid);
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

endmodule

[hw/rtl/sorted_table_binary_search.sv]
// channel | dir | handshake             | payload
// config  | in  | cfg_valid / cfg_ready | table_length
// item    | in  | in_valid / in_stall   | cmd, entry_index, entry_value, search_key, search_mode
// result  | out | out_valid / out_stall | found, match_index, match_count
//
// a write transaction does not make the block busy, it is ready again at once
// a search runs PROBE (table read) and CMP (compare) per probe, plus PROBE at each pass end
// and DONE to hand over; count mode runs two passes, for the leftmost and the rightmost hit
// the probe loop is bound by the single registered read port of the table
// rst_n is asynchronous and clears sequencer, length register and output valid, not the table
// a stalled result sits in the output register while the next search proceeds

module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [LEN_W-1:0]          table_length,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cmd,
    input  logic [IDX_F_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0]   entry_value,
    input  logic signed [VAL_W-1:0]   search_key,
    input  logic [1:0]                search_mode,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [IDX_F_W-1:0]        match_index,
    output logic [CNT_W-1:0]          match_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [LEN_W-1:0]      len_reg;
    logic                  busy;
    logic                  in_take;
    logic                  wr_en;
    logic                  start;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  res_valid;
    res_t                  res;
    logic                  res_ready;
    logic                  out_valid_reg;
    res_t                  out_reg;

    // length register, only written while no search runs
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= table_length;
        end
    end

    // item transactions are taken whenever the sequencer is idle
    assign in_stall = busy;
    assign in_take  = in_valid && !in_stall;

    // writes beyond the table are dropped
    assign wr_en = in_take && (cmd == CMD_WRITE) && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign start = in_take && (cmd == CMD_SEARCH);

    stbs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (DATA_WIDTH'(entry_value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .len       (len_reg),
        .key       (search_key),
        .mode      (search_mode),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register, refilled when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_reg.found;
    assign match_index = out_reg.match_index;
    assign match_count = out_reg.match_count;

endmodule

[hw/rtl/stbs_checker.sv]
module stbs_checker
    import stbs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               cmd,
    input logic               out_valid,
    input logic               out_stall,
    input logic               found,
    input logic [IDX_F_W-1:0] match_index,
    input logic [CNT_W-1:0]   match_count
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found)
            && $stable(match_index) && $stable(match_count))
        else $error("result changed while stalled");

    // a miss carries zero index and zero count
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (match_index == '0) && (match_count == '0))
        else $error("miss with nonzero index or count");

    // index and count are never both set
    a_idx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (match_count != '0) |-> found && (match_index == '0))
        else $error("count result with index or without hit");

    // a search transaction makes the block busy next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_SEARCH) |=> in_stall)
        else $error("not busy after search transaction");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .match_index (match_index),
    .match_count (match_count)
);
